>>> rtl/rpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and constants of the proximity table: item and entry layouts,
// status codes, threshold pair and queue sizing.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int ADDR_W      = 48;
  localparam int RSSI_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_RSSI    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_AVERAGE = 1'd1;

  localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  // -100 dBm and -60 dBm in two's complement
  localparam logic [RSSI_W-1:0] FLOOR_RSSI    = 8'h9C;
  localparam logic [RSSI_W-1:0] THRESHOLD_RST = 8'hC4;

  typedef enum logic [1:0] {
    KIND_REPORT,
    KIND_QUERY,
    KIND_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [RSSI_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [RSSI_W-1:0] last;
    logic [RSSI_W-1:0] avg;
  } entry_t;

  typedef struct packed {
    logic [RSSI_W-1:0] rssi_thr;
    logic [RSSI_W-1:0] avg_thr;
  } thr_t;

endpackage

`default_nettype wire

>>> rtl/rpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/rpt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_front
// Front end: accept a command, classify it as report, query or ignored
// report, and push it into the work queue.
// ----------------------------------------------------------------------------
module rpt_front (
  input  wire logic                       start,
  input  wire logic                       in_mode,
  input  wire logic [rpt_pkg::ADDR_W-1:0] in_mac_address,
  input  wire logic [rpt_pkg::RSSI_W-1:0] in_rssi_sample,
  input  wire logic                       in_service_data_present,
  input  wire logic                       q_full,
  output logic                            busy,
  output logic                            push,
  output rpt_pkg::item_t                  push_item
);

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    push_item.addr   = in_mac_address;
    push_item.sample = in_rssi_sample;
    if (in_mode) begin
      push_item.kind = rpt_pkg::KIND_QUERY;
    end else if (in_service_data_present) begin
      push_item.kind = rpt_pkg::KIND_REPORT;
    end else begin
      push_item.kind = rpt_pkg::KIND_IGNORE;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rpt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_queue
// Short FIFO of classified items between the front end and the table walker.
// ----------------------------------------------------------------------------
module rpt_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rpt_pkg::item_t push_item,
  input  wire logic           pop,
  output rpt_pkg::item_t      pop_item,
  output logic                full,
  output logic                empty
);

  localparam int QPTR_W = (rpt_pkg::QUEUE_DEPTH > 1) ? $clog2(rpt_pkg::QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(rpt_pkg::QUEUE_DEPTH + 1);

  rpt_pkg::item_t    slot_r [rpt_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == QCNT_W'(rpt_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(rpt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(rpt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rpt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_back
// Table walker: pops one item; an ignored report gets its result at once, any
// other reads every table entry in turn from the entry RAM, then writes back the report or returns the query winner.
// ----------------------------------------------------------------------------
module rpt_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rpt_pkg::thr_t               thr,
  input  wire logic                        q_empty,
  input  wire rpt_pkg::item_t              q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  output logic [rpt_pkg::STATUS_W-1:0]     out_report_status,
  output logic                             out_found,
  output logic [rpt_pkg::ADDR_W-1:0]       out_winner_address,
  output logic [rpt_pkg::RSSI_W-1:0]       out_winner_rssi,
  output logic [rpt_pkg::RSSI_W-1:0]       out_winner_average
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t                           state_r;
  state_t                           state_nxt;
  logic [TABLE_ENTRIES-1:0]         valid_r;
  logic [TABLE_ENTRIES-1:0]         valid_nxt;
  logic [IDX_W-1:0]                 idx_r;
  logic [IDX_W-1:0]                 idx_nxt;
  rpt_pkg::item_t                   item_r;
  rpt_pkg::item_t                   item_nxt;
  logic                             hit_r;
  logic                             hit_nxt;
  logic [IDX_W-1:0]                 hit_idx_r;
  logic [IDX_W-1:0]                 hit_idx_nxt;
  logic [rpt_pkg::RSSI_W-1:0]       hit_avg_r;
  logic [rpt_pkg::RSSI_W-1:0]       hit_avg_nxt;
  logic                             free_r;
  logic                             free_nxt;
  logic [IDX_W-1:0]                 free_idx_r;
  logic [IDX_W-1:0]                 free_idx_nxt;
  logic                             found_r;
  logic                             found_nxt;
  logic [rpt_pkg::ADDR_W-1:0]       w_addr_r;
  logic [rpt_pkg::ADDR_W-1:0]       w_addr_nxt;
  logic [rpt_pkg::RSSI_W-1:0]       w_rssi_r;
  logic [rpt_pkg::RSSI_W-1:0]       w_rssi_nxt;
  logic [rpt_pkg::RSSI_W-1:0]       w_avg_r;
  logic [rpt_pkg::RSSI_W-1:0]       w_avg_nxt;

  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic [rpt_pkg::STATUS_W-1:0]     out_status_r;
  logic [rpt_pkg::STATUS_W-1:0]     out_status_nxt;
  logic                             out_found_r;
  logic                             out_found_nxt;
  logic [rpt_pkg::ADDR_W-1:0]       out_addr_r;
  logic [rpt_pkg::ADDR_W-1:0]       out_addr_nxt;
  logic [rpt_pkg::RSSI_W-1:0]       out_rssi_r;
  logic [rpt_pkg::RSSI_W-1:0]       out_rssi_nxt;
  logic [rpt_pkg::RSSI_W-1:0]       out_avg_r;
  logic [rpt_pkg::RSSI_W-1:0]       out_avg_nxt;

  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  rpt_pkg::entry_t                  ram_wdata;
  logic [IDX_W-1:0]                 ram_raddr;
  rpt_pkg::entry_t                  ram_rdata;

  logic                             last_idx;
  logic                             ent_valid;
  logic signed [rpt_pkg::RSSI_W-1:0] ent_last;
  logic signed [rpt_pkg::RSSI_W-1:0] ent_avg;
  logic signed [rpt_pkg::RSSI_W-1:0] cur_w_rssi;
  logic                             qualifies;
  logic                             beats;
  logic signed [rpt_pkg::RSSI_W:0]  avg_sum;
  logic signed [rpt_pkg::RSSI_W:0]  avg_adj;
  logic [rpt_pkg::RSSI_W-1:0]       avg_new;

  rpt_ram #(
    .WIDTH ($bits(rpt_pkg::entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign last_idx   = (idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign ent_valid  = valid_r[idx_r];
  assign ent_last   = ram_rdata.last;
  assign ent_avg    = ram_rdata.avg;
  assign cur_w_rssi = w_rssi_r;
  assign qualifies  = ent_valid
                      && ((ent_last > $signed(thr.rssi_thr)) || (ent_avg > $signed(thr.avg_thr)));
  assign beats      = (ent_last > cur_w_rssi)
                      || (found_r && (ent_last == cur_w_rssi) && (ram_rdata.addr < w_addr_r));

  // truncate toward zero: bias odd negative sums up by one before the shift
  assign avg_sum = {hit_avg_r[rpt_pkg::RSSI_W-1], hit_avg_r}
                   + {item_r.sample[rpt_pkg::RSSI_W-1], item_r.sample};
  assign avg_adj = avg_sum + {{rpt_pkg::RSSI_W{1'b0}}, avg_sum[rpt_pkg::RSSI_W] & avg_sum[0]};
  assign avg_new = avg_adj[rpt_pkg::RSSI_W:1];

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    idx_nxt        = idx_r;
    item_nxt       = item_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_avg_nxt    = hit_avg_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    found_nxt      = found_r;
    w_addr_nxt     = w_addr_r;
    w_rssi_nxt     = w_rssi_r;
    w_avg_nxt      = w_avg_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_addr_nxt   = out_addr_r;
    out_rssi_nxt   = out_rssi_r;
    out_avg_nxt    = out_avg_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          if (q_item.kind == rpt_pkg::KIND_IGNORE) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = rpt_pkg::STATUS_IGNORED;
            out_found_nxt  = 1'b0;
            out_addr_nxt   = '0;
            out_rssi_nxt   = rpt_pkg::FLOOR_RSSI;
            out_avg_nxt    = rpt_pkg::FLOOR_RSSI;
          end else begin
            idx_nxt    = '0;
            hit_nxt    = 1'b0;
            free_nxt   = 1'b0;
            found_nxt  = 1'b0;
            w_addr_nxt = '0;
            w_rssi_nxt = rpt_pkg::FLOOR_RSSI;
            w_avg_nxt  = rpt_pkg::FLOOR_RSSI;
            state_nxt  = S_WALK;
          end
        end
      end
      S_WALK: begin
        ram_raddr = last_idx ? '0 : idx_r + 1'b1;
        if (item_r.kind == rpt_pkg::KIND_QUERY) begin
          if (qualifies && beats) begin
            found_nxt  = 1'b1;
            w_addr_nxt = ram_rdata.addr;
            w_rssi_nxt = ram_rdata.last;
            w_avg_nxt  = ram_rdata.avg;
          end
        end else begin
          if (ent_valid && !hit_r && (ram_rdata.addr == item_r.addr)) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = idx_r;
            hit_avg_nxt = ram_rdata.avg;
          end
          if (!ent_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = idx_r;
          end
        end
        if (last_idx) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FINISH: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (item_r.kind == rpt_pkg::KIND_QUERY) begin
          out_status_nxt = rpt_pkg::STATUS_UPDATED;
          out_found_nxt  = found_r;
          out_addr_nxt   = w_addr_r;
          out_rssi_nxt   = w_rssi_r;
          out_avg_nxt    = w_avg_r;
        end else begin
          out_found_nxt = 1'b0;
          out_addr_nxt  = '0;
          out_rssi_nxt  = rpt_pkg::FLOOR_RSSI;
          out_avg_nxt   = rpt_pkg::FLOOR_RSSI;
          ram_wdata.addr = item_r.addr;
          ram_wdata.last = item_r.sample;
          if (hit_r) begin
            ram_we         = 1'b1;
            ram_waddr      = hit_idx_r;
            ram_wdata.avg  = avg_new;
            out_status_nxt = rpt_pkg::STATUS_UPDATED;
          end else if (free_r) begin
            ram_we               = 1'b1;
            ram_waddr            = free_idx_r;
            ram_wdata.avg        = item_r.sample;
            valid_nxt[free_idx_r] = 1'b1;
            out_status_nxt       = rpt_pkg::STATUS_INSERTED;
          end else begin
            out_status_nxt = rpt_pkg::STATUS_FULL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    item_r       <= item_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_avg_r    <= hit_avg_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    found_r      <= found_nxt;
    w_addr_r     <= w_addr_nxt;
    w_rssi_r     <= w_rssi_nxt;
    w_avg_r      <= w_avg_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_addr_r   <= out_addr_nxt;
    out_rssi_r   <= out_rssi_nxt;
    out_avg_r    <= out_avg_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_report_status  = out_status_r;
  assign out_found          = out_found_r;
  assign out_winner_address = out_addr_r;
  assign out_winner_rssi    = out_rssi_r;
  assign out_winner_average = out_avg_r;

endmodule

`default_nettype wire

>>> rtl/rssi_proximity_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssi_proximity_table_core
// Device proximity table: reports update or insert devices keyed by address,
// queries return the strongest qualifying device.
//
//   channel  ports                                  transfer when
//   input    start, busy, in_*                      start && !busy
//   result   out_valid, out_*                       out_valid (one cycle)
//   config   cfg_we, cfg_index, cfg_data            cfg_we
//
// Reports and queries are walked one item at a time: one entry RAM read per
// entry, then a finish state for write-back and result.
// Reports without service data get their result without a walk.
// A two-item queue decouples the front end; busy is high while it is full.
// Reset clears the entry valid bits at once; no clearing pass is needed.
// Results are presented for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rssi_proximity_table_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_mode,
  input  wire logic [rpt_pkg::ADDR_W-1:0]    in_mac_address,
  input  wire logic [rpt_pkg::RSSI_W-1:0]    in_rssi_sample,
  input  wire logic                          in_service_data_present,
  output logic                               out_valid,
  output logic [rpt_pkg::STATUS_W-1:0]       out_report_status,
  output logic                               out_found,
  output logic [rpt_pkg::ADDR_W-1:0]         out_winner_address,
  output logic signed [rpt_pkg::RSSI_W-1:0]  out_winner_rssi,
  output logic signed [rpt_pkg::RSSI_W-1:0]  out_winner_average,
  input  wire logic                          cfg_we,
  input  wire logic [rpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rpt_pkg::RSSI_W-1:0]    cfg_data
);

  rpt_pkg::thr_t  thr_r;
  rpt_pkg::thr_t  thr_nxt;
  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  rpt_pkg::item_t q_push_item;
  rpt_pkg::item_t q_pop_item;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rpt_pkg::CFG_LOCK_RSSI:    thr_nxt.rssi_thr = cfg_data;
        rpt_pkg::CFG_LOCK_AVERAGE: thr_nxt.avg_thr  = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.rssi_thr <= rpt_pkg::THRESHOLD_RST;
      thr_r.avg_thr  <= rpt_pkg::THRESHOLD_RST;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  rpt_front u_front (
    .start                   (start),
    .in_mode                 (in_mode),
    .in_mac_address          (in_mac_address),
    .in_rssi_sample          (in_rssi_sample),
    .in_service_data_present (in_service_data_present),
    .q_full                  (q_full),
    .busy                    (busy),
    .push                    (q_push),
    .push_item               (q_push_item)
  );

  rpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  rpt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .thr                (thr_r),
    .q_empty            (q_empty),
    .q_item             (q_pop_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_report_status  (out_report_status),
    .out_found          (out_found),
    .out_winner_address (out_winner_address),
    .out_winner_rssi    (out_winner_rssi),
    .out_winner_average (out_winner_average)
  );

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !q_empty)
    else $error("accepted transfer not held in queue");

  a_winner_above_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_winner_rssi > $signed(rpt_pkg::FLOOR_RSSI)))
    else $error("winner not above floor");

  a_report_no_winner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_report_status != rpt_pkg::STATUS_UPDATED)) |-> !out_found)
    else $error("report result flags a winner");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
